FILE: rtl/core/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

    // Grid store geometry
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int GW_W        = $clog2(MAX_COLUMNS + 1);
    localparam int GH_W        = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W      = $clog2(MAX_COLUMNS * MAX_ROWS);

    // Field widths
    localparam int KIND_W      = 2;
    localparam int FIELD_CR_W  = 8;
    localparam int COORD_W     = 17;
    localparam int HEIGHT_W    = 16;
    localparam int OUT_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Arithmetic widths
    localparam int XS_W        = FRAC_W + COL_W;
    localparam int YS_W        = FRAC_W + ROW_W;
    localparam int WGT_W       = FRAC_W + 1;
    localparam int HSUM_W      = HEIGHT_W + FRAC_W;
    localparam int ACC_W       = HSUM_W + FRAC_W;

    localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(1) << FRAC_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

    // Item kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_LOAD   = 2'd0;
    localparam t_kind KIND_POINT  = 2'd1;
    localparam t_kind KIND_SAMPLE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCALE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MAC,
        S_VACC,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        ADDR_POINT,
        ADDR_00,
        ADDR_10,
        ADDR_01,
        ADDR_11
    } t_addr_sel;

    typedef enum logic [1:0] {
        RES_FLAG,
        RES_POINT,
        RES_SAMPLE
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      wr_en;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      scale_en;
        logic      mac_en;
        logic      mac_first;
        logic      mac_wsel;
        logic      vacc_en;
        logic      vacc_first;
        logic      vacc_wsel;
        logic      out_load;
        t_res_sel  res_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  in_grid;
        logic  sample_bad;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/hbs_datapath.sv
`default_nettype none

module hbs_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire hbs_pkg::t_dp_cmd            i_cmd,
    output hbs_pkg::t_dp_status              o_status,
    input  wire [hbs_pkg::KIND_W-1:0]        i_kind,
    input  wire [hbs_pkg::FIELD_CR_W-1:0]    i_column,
    input  wire [hbs_pkg::FIELD_CR_W-1:0]    i_row,
    input  wire [hbs_pkg::COORD_W-1:0]       i_u_coord,
    input  wire [hbs_pkg::COORD_W-1:0]       i_v_coord,
    input  wire [hbs_pkg::HEIGHT_W-1:0]      i_height_in,
    input  wire                              i_cfg_we,
    input  wire [hbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [hbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [hbs_pkg::OUT_W-1:0]        o_height_out,
    output logic                             o_out_of_range
);

    // Grid size registers, held already clamped to the store size
    logic [hbs_pkg::GW_W-1:0] r_grid_w;
    logic [hbs_pkg::GH_W-1:0] r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= '0;
            r_grid_h <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hbs_pkg::CFG_GRID_WIDTH) begin
                r_grid_w <= (32'(i_cfg_data) > 32'(hbs_pkg::MAX_COLUMNS)) ?
                            hbs_pkg::GW_W'(hbs_pkg::MAX_COLUMNS) :
                            hbs_pkg::GW_W'(i_cfg_data);
            end
            if (i_cfg_index == hbs_pkg::CFG_GRID_HEIGHT) begin
                r_grid_h <= (32'(i_cfg_data) > 32'(hbs_pkg::MAX_ROWS)) ?
                            hbs_pkg::GH_W'(hbs_pkg::MAX_ROWS) :
                            hbs_pkg::GH_W'(i_cfg_data);
            end
        end
    end

    // Item capture
    hbs_pkg::t_kind                    r_kind;
    logic [hbs_pkg::FIELD_CR_W-1:0]    r_col;
    logic [hbs_pkg::FIELD_CR_W-1:0]    r_row;
    logic [hbs_pkg::COORD_W-1:0]       r_u;
    logic [hbs_pkg::COORD_W-1:0]       r_v;
    logic [hbs_pkg::HEIGHT_W-1:0]      r_hin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_col  <= i_column;
            r_row  <= i_row;
            r_u    <= i_u_coord;
            r_v    <= i_v_coord;
            r_hin  <= i_height_in;
        end
    end

    // Status decode
    always_comb begin
        o_status.kind       = r_kind;
        o_status.in_grid    = (32'(r_col) < 32'(r_grid_w)) &&
                              (32'(r_row) < 32'(r_grid_h));
        o_status.sample_bad = (r_grid_w == '0) || (r_grid_h == '0) ||
                              (r_u > hbs_pkg::ONE_Q16) || (r_v > hbs_pkg::ONE_Q16);
    end

    // Coordinate scaling by size less one
    logic [hbs_pkg::COORD_W+hbs_pkg::GW_W-1:0] prod_x;
    logic [hbs_pkg::COORD_W+hbs_pkg::GH_W-1:0] prod_y;
    logic [hbs_pkg::XS_W-1:0]                  r_xs;
    logic [hbs_pkg::YS_W-1:0]                  r_ys;

    assign prod_x = r_u * (r_grid_w - hbs_pkg::GW_W'(1));
    assign prod_y = r_v * (r_grid_h - hbs_pkg::GH_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_en) begin
            r_xs <= prod_x[hbs_pkg::XS_W-1:0];
            r_ys <= prod_y[hbs_pkg::YS_W-1:0];
        end
    end

    // Neighbour indexes and weights
    logic [hbs_pkg::COL_W-1:0]  x0, x1;
    logic [hbs_pkg::ROW_W-1:0]  y0, y1;
    logic [hbs_pkg::FRAC_W-1:0] s, t;
    logic [hbs_pkg::WGT_W-1:0]  ws0, ws1, wt0, wt1;

    always_comb begin
        x0  = r_xs[hbs_pkg::FRAC_W +: hbs_pkg::COL_W];
        y0  = r_ys[hbs_pkg::FRAC_W +: hbs_pkg::ROW_W];
        s   = r_xs[hbs_pkg::FRAC_W-1:0];
        t   = r_ys[hbs_pkg::FRAC_W-1:0];
        x1  = x0 + hbs_pkg::COL_W'(s != '0);
        y1  = y0 + hbs_pkg::ROW_W'(t != '0);
        ws1 = {1'b0, s};
        wt1 = {1'b0, t};
        ws0 = hbs_pkg::ONE_Q16 - ws1;
        wt0 = hbs_pkg::ONE_Q16 - wt1;
    end

    // Store address: row * MAX_COLUMNS + column
    function automatic logic [hbs_pkg::ADDR_W-1:0] cell_addr(
        input logic [hbs_pkg::COL_W-1:0] x,
        input logic [hbs_pkg::ROW_W-1:0] y
    );
        return hbs_pkg::ADDR_W'(y) * hbs_pkg::ADDR_W'(hbs_pkg::MAX_COLUMNS) +
               hbs_pkg::ADDR_W'(x);
    endfunction

    logic [hbs_pkg::ADDR_W-1:0] addr;

    always_comb begin
        unique case (i_cmd.addr_sel)
            hbs_pkg::ADDR_00: addr = cell_addr(x0, y0);
            hbs_pkg::ADDR_10: addr = cell_addr(x1, y0);
            hbs_pkg::ADDR_01: addr = cell_addr(x0, y1);
            hbs_pkg::ADDR_11: addr = cell_addr(x1, y1);
            default:          addr = cell_addr(hbs_pkg::COL_W'(r_col),
                                               hbs_pkg::ROW_W'(r_row));
        endcase
    end

    // Height store, one port, registered read
    logic [hbs_pkg::HEIGHT_W-1:0] r_store [hbs_pkg::MAX_COLUMNS*hbs_pkg::MAX_ROWS];
    logic [hbs_pkg::HEIGHT_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && o_status.in_grid) begin
            r_store[addr] <= r_hin;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_store[addr];
        end
    end

    // Horizontal blend: one product per cycle
    logic [hbs_pkg::HEIGHT_W+hbs_pkg::WGT_W-1:0] prod_h;
    logic [hbs_pkg::HSUM_W-1:0]                  r_hsum;

    assign prod_h = r_rd * (i_cmd.mac_wsel ? ws1 : ws0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_hsum <= (i_cmd.mac_first ? '0 : r_hsum) + prod_h[hbs_pkg::HSUM_W-1:0];
        end
    end

    // Vertical blend
    logic [hbs_pkg::HSUM_W+hbs_pkg::WGT_W-1:0] prod_v;
    logic [hbs_pkg::ACC_W-1:0]                 r_acc;

    assign prod_v = r_hsum * (i_cmd.vacc_wsel ? wt1 : wt0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.vacc_en) begin
            r_acc <= (i_cmd.vacc_first ? '0 : r_acc) + prod_v[hbs_pkg::ACC_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.res_sel)
                hbs_pkg::RES_POINT: begin
                    o_height_out   <= {r_rd, hbs_pkg::FRAC_W'(0)};
                    o_out_of_range <= 1'b0;
                end
                hbs_pkg::RES_SAMPLE: begin
                    o_height_out   <= r_acc[hbs_pkg::FRAC_W +: hbs_pkg::OUT_W];
                    o_out_of_range <= 1'b0;
                end
                default: begin
                    o_height_out   <= '0;
                    o_out_of_range <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hbs_ctrl.sv
`default_nettype none

module hbs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  wire hbs_pkg::t_dp_status i_status,
    output hbs_pkg::t_dp_cmd      o_cmd
);

    hbs_pkg::t_state   r_state, n_state;
    hbs_pkg::t_res_sel r_sel, n_sel;
    logic              r_out_valid, n_out_valid;

    // State, result select and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbs_pkg::S_IDLE;
            r_sel       <= hbs_pkg::RES_FLAG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.addr_sel = hbs_pkg::ADDR_POINT;
        o_cmd.res_sel  = r_sel;

        unique case (r_state)
            hbs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = hbs_pkg::S_DECODE;
                end
            end
            hbs_pkg::S_DECODE: begin
                unique case (i_status.kind)
                    hbs_pkg::KIND_LOAD: begin
                        o_cmd.wr_en = 1'b1;
                        n_state     = hbs_pkg::S_IDLE;
                    end
                    hbs_pkg::KIND_POINT: begin
                        if (i_status.in_grid) begin
                            o_cmd.rd_en = 1'b1;
                            n_sel       = hbs_pkg::RES_POINT;
                        end else begin
                            n_sel = hbs_pkg::RES_FLAG;
                        end
                        n_state = hbs_pkg::S_EMIT;
                    end
                    hbs_pkg::KIND_SAMPLE: begin
                        if (i_status.sample_bad) begin
                            n_sel   = hbs_pkg::RES_FLAG;
                            n_state = hbs_pkg::S_EMIT;
                        end else begin
                            o_cmd.scale_en = 1'b1;
                            n_state        = hbs_pkg::S_RD0;
                        end
                    end
                    default: begin
                        n_state = hbs_pkg::S_IDLE;
                    end
                endcase
            end
            hbs_pkg::S_RD0: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = hbs_pkg::ADDR_00;
                n_state        = hbs_pkg::S_RD1;
            end
            hbs_pkg::S_RD1: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.addr_sel  = hbs_pkg::ADDR_10;
                o_cmd.mac_en    = 1'b1;
                o_cmd.mac_first = 1'b1;
                n_state         = hbs_pkg::S_RD2;
            end
            hbs_pkg::S_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = hbs_pkg::ADDR_01;
                o_cmd.mac_en   = 1'b1;
                o_cmd.mac_wsel = 1'b1;
                n_state        = hbs_pkg::S_RD3;
            end
            hbs_pkg::S_RD3: begin
                // upper row done: weight it while the lower row starts
                o_cmd.rd_en      = 1'b1;
                o_cmd.addr_sel   = hbs_pkg::ADDR_11;
                o_cmd.mac_en     = 1'b1;
                o_cmd.mac_first  = 1'b1;
                o_cmd.vacc_en    = 1'b1;
                o_cmd.vacc_first = 1'b1;
                n_state          = hbs_pkg::S_MAC;
            end
            hbs_pkg::S_MAC: begin
                o_cmd.mac_en   = 1'b1;
                o_cmd.mac_wsel = 1'b1;
                n_state        = hbs_pkg::S_VACC;
            end
            hbs_pkg::S_VACC: begin
                o_cmd.vacc_en   = 1'b1;
                o_cmd.vacc_wsel = 1'b1;
                n_sel           = hbs_pkg::RES_SAMPLE;
                n_state         = hbs_pkg::S_EMIT;
            end
            hbs_pkg::S_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hbs_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_capture_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == hbs_pkg::S_DECODE))
        else $error("accepted item not decoded");

    a_valid_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_out_ready))
        else $error("result dropped without transfer");

    a_emit_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::S_VACC) |=>
            (r_state == hbs_pkg::S_EMIT && r_sel == hbs_pkg::RES_SAMPLE))
        else $error("sample result select lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/heightmap_bilinear_sampler_core.sv
`default_nettype none

// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_kind i_column i_row i_u_coord i_v_coord i_height_in
// output    o_out_valid / i_out_ready  o_height_out o_out_of_range
// config    i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// Items are a load, a point lookup or a bilinear sample; the next item is taken only
// once the last is through. A sample makes four reads of the single-port store.
// Synchronous active-low reset clears the FSM, output valid and grid size; the store
// is not cleared. A result waits in the output register while the next item is taken;
// only a second result stalls until the first has been transferred.
module heightmap_bilinear_sampler_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [hbs_pkg::KIND_W-1:0]         i_kind,
    input  wire [hbs_pkg::FIELD_CR_W-1:0]     i_column,
    input  wire [hbs_pkg::FIELD_CR_W-1:0]     i_row,
    input  wire [hbs_pkg::COORD_W-1:0]        i_u_coord,
    input  wire [hbs_pkg::COORD_W-1:0]        i_v_coord,
    input  wire [hbs_pkg::HEIGHT_W-1:0]       i_height_in,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [hbs_pkg::OUT_W-1:0]         o_height_out,
    output logic                              o_out_of_range,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [hbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [hbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    hbs_pkg::t_dp_cmd    cmd;
    hbs_pkg::t_dp_status status;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    hbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (i_kind),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_u_coord      (i_u_coord),
        .i_v_coord      (i_v_coord),
        .i_height_in    (i_height_in),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_height_out   (o_height_out),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire
